// File: src/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the lottery scheduler
// sizes, widths, register map, func codes, sequencer states, cell control struct
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int SLOTS    = 16;
  localparam int CPUS     = 4;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = 5;
  localparam int TKT_W    = 8;
  localparam int WORK_W   = 16;
  localparam int SUM_W    = 12;
  localparam int QNT_W    = 8;
  localparam int ACT_W    = 3;
  localparam int CPU_W    = 2;
  localparam int RAND_W   = 16;
  localparam int ADDR_W   = 3;
  localparam logic [QNT_W-1:0] QUANTUM_RESET = 8'd3;

  localparam logic [ADDR_W-1:0] REG_QUANTUM = 3'd0;
  localparam logic [ADDR_W-1:0] REG_ACTIVE  = 3'd4;

  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_SUM,
    ST_MOD,
    ST_SCAN,
    ST_TAKE,
    ST_RUN,
    ST_OUT
  } state_t;

  // commands from the sequencer to the list cells
  typedef struct packed {
    logic              push;      // append at tail (index count)
    logic [SLOT_W-1:0] push_slot;
    logic              rotate;    // shift whole list left by one, head to tail
    logic              remove;    // drop head entry during a rotation
  } cell_ctl_t;

endpackage

// File: src/lcs_if.sv
// ----------------------------------------------------------------------------
// lcs_in_if / lcs_out_if: valid-ready channels of the scheduler
// one beat carries one input item or one result item
// ----------------------------------------------------------------------------
interface lcs_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  slot;
  logic [7:0]  tickets;
  logic [15:0] burst;
  logic [15:0] rand_0;
  logic [15:0] rand_1;
  logic [15:0] rand_2;
  logic [15:0] rand_3;
  modport source (output valid, func, slot, tickets, burst, rand_0, rand_1, rand_2,
                  rand_3, input ready);
  modport sink (input valid, func, slot, tickets, burst, rand_0, rand_1, rand_2,
                rand_3, output ready);
endinterface

interface lcs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cpu;
  logic       busy_res;
  logic [3:0] running_slot;
  logic       dispatched;
  logic       finished;
  logic [3:0] finished_slot;
  logic       last;
  modport source (output valid, cpu, busy_res, running_slot, dispatched, finished,
                  finished_slot, last, input ready);
  modport sink (input valid, cpu, busy_res, running_slot, dispatched, finished,
                finished_slot, last, output ready);
endinterface

// File: src/lottery_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// lottery_cpu_scheduler: ticket-weighted lottery scheduler for up to 4 CPUs
// Admit: one item per cycle while idle. Tick: a retire pass over the active
// CPUs; per idle CPU a ticket sum pass, 16-step restoring modulo and scan
// pass through the cell row; a run pass; one result beat per active CPU.
// One item is worked on at a time. Synchronous active-low reset idles all
// CPUs, empties the ready list and loads quantum 3, one active CPU.
// ----------------------------------------------------------------------------
module lottery_cpu_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  lcs_in_if.sink      in_ch,
  lcs_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int SW = lcs_pkg::SLOT_W;
  localparam int CW = lcs_pkg::CNT_W;

  lcs_pkg::state_t state_r, state_nxt;
  logic [lcs_pkg::QNT_W-1:0] quantum_r;
  logic [lcs_pkg::ACT_W-1:0] active_r;

  logic [lcs_pkg::TKT_W-1:0]  tkt_r  [lcs_pkg::SLOTS];
  logic [lcs_pkg::WORK_W-1:0] rem_r  [lcs_pkg::SLOTS];
  logic [SW-1:0]              cslot_r[lcs_pkg::CPUS];
  logic [lcs_pkg::CPUS-1:0]   busy_r, disp_r, fin_r;
  logic [SW-1:0]              fslot_r[lcs_pkg::CPUS];
  logic [lcs_pkg::QNT_W-1:0]  qleft_r[lcs_pkg::CPUS];
  logic [CW-1:0]              count_r;
  logic [lcs_pkg::RAND_W-1:0] rand_r [lcs_pkg::CPUS];

  logic [lcs_pkg::CPU_W-1:0]  cpu_r;
  logic [CW-1:0]              idx_r;
  logic [lcs_pkg::SUM_W-1:0]  sum_r;
  logic [lcs_pkg::SUM_W-1:0]  rem_acc_r;   // modulo partial remainder
  logic [lcs_pkg::RAND_W-1:0] dvd_r;
  logic [4:0]                 mstep_r;
  logic                       found_r;
  logic [CW-1:0]              nact_m1;
  logic [2:0]                 nact;

  lcs_pkg::cell_ctl_t ctl;
  logic [SW-1:0] head;

  // output register
  logic       ov_r;
  logic [1:0] o_cpu_r;
  logic       o_busy_r, o_disp_r, o_fin_r, o_last_r;
  logic [3:0] o_rs_r, o_fs_r;

  lcs_ready_chain u_chain (.clk(clk), .ctl(ctl), .count(count_r), .head_slot(head));

  always_comb begin
    if (active_r == 3'd0) nact = 3'd1;
    else if (active_r > 3'(lcs_pkg::CPUS)) nact = 3'(lcs_pkg::CPUS);
    else nact = active_r;
  end
  assign nact_m1 = CW'(nact) - CW'(1);

  logic in_fire, cfg_wr;
  assign in_ch.ready = (state_r == lcs_pkg::ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr)
      lcs_pkg::REG_QUANTUM: cfg_prdata = {24'd0, quantum_r};
      lcs_pkg::REG_ACTIVE:  cfg_prdata = {29'd0, active_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // modulo step: shift in one dividend bit, subtract if it fits
  logic [lcs_pkg::SUM_W:0] trial;
  assign trial = {rem_acc_r, dvd_r[lcs_pkg::RAND_W-1]} - {1'b0, sum_r};

  logic [lcs_pkg::SUM_W-1:0] cum_nxt;
  assign cum_nxt = sum_r + lcs_pkg::SUM_W'(tkt_r[head]);

  logic bz, oready;
  assign bz = busy_r[cpu_r];
  assign oready = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      lcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.func == lcs_pkg::FUNC_ADMIT) begin
            ctl.push = (32'(count_r) + 32'($countones(busy_r)) < lcs_pkg::SLOTS);
            ctl.push_slot = in_ch.slot;
          end else begin
            state_nxt = lcs_pkg::ST_RETIRE;
          end
        end
      end
      lcs_pkg::ST_RETIRE: begin
        if (bz && rem_r[cslot_r[cpu_r]] != '0 && qleft_r[cpu_r] == '0) begin
          ctl.push = 1'b1;
          ctl.push_slot = cslot_r[cpu_r];
        end
        if (CW'(cpu_r) == nact_m1) state_nxt = lcs_pkg::ST_SUM;
      end
      lcs_pkg::ST_SUM: begin
        if (bz || count_r == '0) begin
          state_nxt = lcs_pkg::ST_TAKE;
        end else if (idx_r == count_r) begin
          state_nxt = lcs_pkg::ST_MOD;
        end else begin
          ctl.rotate = 1'b1;
        end
      end
      lcs_pkg::ST_MOD: begin
        if (sum_r == '0) state_nxt = lcs_pkg::ST_TAKE;
        else if (mstep_r == 5'd16) state_nxt = lcs_pkg::ST_SCAN;
      end
      lcs_pkg::ST_SCAN: begin
        if (idx_r == count_r) begin
          state_nxt = lcs_pkg::ST_TAKE;
        end else begin
          ctl.rotate = 1'b1;
          ctl.remove = !found_r && (cum_nxt > rem_acc_r);
        end
      end
      lcs_pkg::ST_TAKE: begin
        if (CW'(cpu_r) == nact_m1) state_nxt = lcs_pkg::ST_RUN;
        else state_nxt = lcs_pkg::ST_SUM;
      end
      lcs_pkg::ST_RUN: begin
        if (CW'(cpu_r) == nact_m1) state_nxt = lcs_pkg::ST_OUT;
      end
      lcs_pkg::ST_OUT: begin
        if (oready && CW'(cpu_r) == nact_m1) state_nxt = lcs_pkg::ST_IDLE;
      end
      default: state_nxt = lcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lcs_pkg::ST_IDLE;
      quantum_r <= lcs_pkg::QUANTUM_RESET;
      active_r  <= 3'd1;
      count_r   <= '0;
      busy_r    <= '0;
      cpu_r     <= '0;
      ov_r      <= 1'b0;
      for (int c = 0; c < lcs_pkg::CPUS; c++) begin
        cslot_r[c] <= '0;
        qleft_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == lcs_pkg::REG_QUANTUM) quantum_r <= cfg_pwdata[7:0];
      if (cfg_wr && cfg_paddr == lcs_pkg::REG_ACTIVE)  active_r  <= cfg_pwdata[2:0];
      if (state_r == lcs_pkg::ST_OUT && oready) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      if (ctl.push) count_r <= count_r + CW'(1);
      if (ctl.remove) begin
        count_r <= count_r - CW'(1);
      end
      unique case (state_r)
        lcs_pkg::ST_IDLE: begin
          cpu_r <= '0;
          if (in_fire && in_ch.func == lcs_pkg::FUNC_ADMIT && ctl.push) begin
            tkt_r[in_ch.slot] <= in_ch.tickets;
            rem_r[in_ch.slot] <= in_ch.burst;
          end
          rand_r[0] <= in_ch.rand_0;
          rand_r[1] <= in_ch.rand_1;
          rand_r[2] <= in_ch.rand_2;
          rand_r[3] <= in_ch.rand_3;
          disp_r <= '0;
          fin_r  <= '0;
          idx_r  <= '0;
          sum_r  <= '0;
        end
        lcs_pkg::ST_RETIRE: begin
          fslot_r[cpu_r] <= (bz && rem_r[cslot_r[cpu_r]] == '0) ? cslot_r[cpu_r] : '0;
          if (bz) begin
            if (rem_r[cslot_r[cpu_r]] == '0) begin
              fin_r[cpu_r]   <= 1'b1;
              busy_r[cpu_r]  <= 1'b0;
            end else if (qleft_r[cpu_r] == '0) begin
              busy_r[cpu_r]  <= 1'b0;
            end
          end
          cpu_r <= (CW'(cpu_r) == nact_m1) ? '0 : cpu_r + 2'd1;
        end
        lcs_pkg::ST_SUM: begin
          if (state_nxt == lcs_pkg::ST_MOD) begin
            rem_acc_r <= '0;
            dvd_r     <= rand_r[cpu_r];
            mstep_r   <= '0;
          end else if (ctl.rotate) begin
            sum_r <= cum_nxt;
            idx_r <= idx_r + CW'(1);
          end
        end
        lcs_pkg::ST_MOD: begin
          if (mstep_r == 5'd16) begin
            idx_r   <= '0;
            sum_r   <= '0;
            found_r <= 1'b0;
          end else begin
            mstep_r <= mstep_r + 5'd1;
            dvd_r   <= dvd_r << 1;
            if (!trial[lcs_pkg::SUM_W]) rem_acc_r <= trial[lcs_pkg::SUM_W-1:0];
            else rem_acc_r <= {rem_acc_r[lcs_pkg::SUM_W-2:0], dvd_r[lcs_pkg::RAND_W-1]};
          end
        end
        lcs_pkg::ST_SCAN: begin
          if (ctl.rotate) begin
            sum_r <= cum_nxt;
            if (ctl.remove) begin
              found_r        <= 1'b1;
              cslot_r[cpu_r] <= head;
              busy_r[cpu_r]  <= 1'b1;
              qleft_r[cpu_r] <= quantum_r;
              disp_r[cpu_r]  <= 1'b1;
              // list shrinks, so the walk ends one position earlier
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        lcs_pkg::ST_TAKE: begin
          idx_r <= '0;
          sum_r <= '0;
          cpu_r <= (CW'(cpu_r) == nact_m1) ? '0 : cpu_r + 2'd1;
        end
        lcs_pkg::ST_RUN: begin
          if (bz) begin
            if (rem_r[cslot_r[cpu_r]] != '0)
              rem_r[cslot_r[cpu_r]] <= rem_r[cslot_r[cpu_r]] - 16'd1;
            if (qleft_r[cpu_r] != '0) qleft_r[cpu_r] <= qleft_r[cpu_r] - 8'd1;
          end
          cpu_r <= (CW'(cpu_r) == nact_m1) ? '0 : cpu_r + 2'd1;
        end
        lcs_pkg::ST_OUT: begin
          if (oready) begin
            o_cpu_r  <= cpu_r;
            o_busy_r <= bz;
            o_rs_r   <= bz ? cslot_r[cpu_r] : '0;
            o_disp_r <= disp_r[cpu_r];
            o_fin_r  <= fin_r[cpu_r];
            o_fs_r   <= fslot_r[cpu_r];
            o_last_r <= (CW'(cpu_r) == nact_m1);
            cpu_r    <= cpu_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.cpu           = o_cpu_r;
  assign out_ch.busy_res      = o_busy_r;
  assign out_ch.running_slot  = o_rs_r;
  assign out_ch.dispatched    = o_disp_r;
  assign out_ch.finished      = o_fin_r;
  assign out_ch.finished_slot = o_fs_r;
  assign out_ch.last          = o_last_r;
endmodule

// File: src/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell: one ready-list position
// holds a slot id, takes it from the right neighbor or the head on a rotation
// ----------------------------------------------------------------------------
module lcs_cell (
  input  logic                      clk,
  input  lcs_pkg::cell_ctl_t        ctl,
  input  logic                      is_tail,       // position == count
  input  logic                      is_rot_tail,   // position == count-1
  input  logic [lcs_pkg::SLOT_W-1:0] right_slot,
  input  logic [lcs_pkg::SLOT_W-1:0] head_slot,
  output logic [lcs_pkg::SLOT_W-1:0] slot_q
);
  logic [lcs_pkg::SLOT_W-1:0] slot_r;
  logic [lcs_pkg::SLOT_W-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.push && is_tail) begin
      slot_nxt = ctl.push_slot;
    end else if (ctl.rotate) begin
      // head wraps to the tail unless it is being removed
      slot_nxt = (is_rot_tail && !ctl.remove) ? head_slot : right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q = slot_r;
endmodule

// File: src/lcs_ready_chain.sv
// ----------------------------------------------------------------------------
// lcs_ready_chain: row of list cells forming the ordered ready list
// rotation walks every entry past the head, one per cycle
// ----------------------------------------------------------------------------
module lcs_ready_chain (
  input  logic                       clk,
  input  lcs_pkg::cell_ctl_t         ctl,
  input  logic [lcs_pkg::CNT_W-1:0]  count,
  output logic [lcs_pkg::SLOT_W-1:0] head_slot
);
  logic [lcs_pkg::SLOT_W-1:0] slot_q [lcs_pkg::SLOTS];
  logic [lcs_pkg::CNT_W-1:0]  rot_last;

  // on a removing rotation the list shrinks: fill position count-1 from right
  assign rot_last = count - lcs_pkg::CNT_W'(1);

  for (genvar i = 0; i < lcs_pkg::SLOTS; i++) begin : g_cell
    logic [lcs_pkg::SLOT_W-1:0] right;
    if (i == lcs_pkg::SLOTS - 1) begin : g_end
      assign right = slot_q[0];
    end else begin : g_mid
      assign right = slot_q[i+1];
    end
    lcs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .is_tail    (count == lcs_pkg::CNT_W'(i)),
      .is_rot_tail(rot_last == lcs_pkg::CNT_W'(i)),
      .right_slot (right),
      .head_slot  (slot_q[0]),
      .slot_q     (slot_q[i])
    );
  end

  assign head_slot = slot_q[0];
endmodule

// File: src/lcs_checker.sv
// ----------------------------------------------------------------------------
// lcs_port_checks: port-level checks of the scheduler
// result ordering and idle behavior seen on the channels
// ----------------------------------------------------------------------------
module lcs_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_cpu,
  input logic       out_last,
  input logic       out_busy,
  input logic [3:0] out_rs,
  input logic       out_fin,
  input logic [3:0] out_fs
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_cpu, out_last, out_busy, out_rs, out_fin, out_fs}))
    else $error("stalled beat changed");
  // the input stays closed until the last result of a tick is loaded
  a_no_in_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open before last result");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_cpu == $past(out_cpu) + 2'd1)
    else $error("results not in cpu order");
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy |-> out_rs == 4'd0)
    else $error("idle cpu shows a slot");
  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fin |-> out_fs == 4'd0)
    else $error("finished slot without finish");
endmodule

bind lottery_cpu_scheduler lcs_port_checks u_lcs_port_checks (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_cpu(out_ch.cpu),
  .out_last(out_ch.last), .out_busy(out_ch.busy_res), .out_rs(out_ch.running_slot),
  .out_fin(out_ch.finished), .out_fs(out_ch.finished_slot)
);

// File: sim/lcs_checker.sv
// ----------------------------------------------------------------------------
// lcs_checker: result predictor and comparator for the lottery scheduler
// watches accepted beats on both channels and the register writes, keeps its
// own copy of the ready list, slot tables and cpu state, and counts mismatches
// ----------------------------------------------------------------------------
module lcs_checker (
  input  logic        clk,
  input  logic        rst_n,
  lcs_in_if           in_ch,
  lcs_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          sched_pending
);

  typedef struct packed {
    logic [lcs_pkg::CPU_W-1:0]  cpu;
    logic                       busy_res;
    logic [lcs_pkg::SLOT_W-1:0] running_slot;
    logic                       dispatched;
    logic                       finished;
    logic [lcs_pkg::SLOT_W-1:0] finished_slot;
    logic                       last;
  } sched_res_t;

  sched_res_t                 sched_q[$];
  logic [lcs_pkg::QNT_W-1:0]  quantum_len;
  logic [lcs_pkg::ACT_W-1:0]  active_reg;
  logic [lcs_pkg::SLOT_W-1:0] rlist[lcs_pkg::SLOTS];
  int                         rcount;
  logic [lcs_pkg::TKT_W-1:0]  tkts[lcs_pkg::SLOTS];
  logic [lcs_pkg::WORK_W-1:0] work_left[lcs_pkg::SLOTS];
  logic [lcs_pkg::SLOT_W-1:0] run_slot[lcs_pkg::CPUS];
  logic                       run_busy[lcs_pkg::CPUS];
  logic [lcs_pkg::QNT_W-1:0]  qleft[lcs_pkg::CPUS];

  task automatic schedule_tick(input logic [lcs_pkg::RAND_W-1:0] rnd[lcs_pkg::CPUS]);
    int n_act, total, win, cumul;
    logic disp[lcs_pkg::CPUS], fin[lcs_pkg::CPUS];
    logic [lcs_pkg::SLOT_W-1:0] fslot[lcs_pkg::CPUS];
    sched_res_t r;
    n_act = active_reg;
    if (n_act == 0) n_act = 1;
    if (n_act > lcs_pkg::CPUS) n_act = lcs_pkg::CPUS;
    for (int c = 0; c < n_act; c++) begin
      disp[c] = 0; fin[c] = 0; fslot[c] = '0;
      if (!run_busy[c]) continue;
      if (work_left[run_slot[c]] == 0) begin
        fin[c] = 1; fslot[c] = run_slot[c]; run_busy[c] = 0;
      end else if (qleft[c] == 0) begin
        if (rcount < lcs_pkg::SLOTS) begin
          rlist[rcount] = run_slot[c]; rcount++;
        end
        run_busy[c] = 0;
      end
    end
    for (int c = 0; c < n_act; c++) begin
      if (run_busy[c] || rcount == 0) continue;
      total = 0;
      for (int j = 0; j < rcount; j++) total += tkts[rlist[j]];
      if (total == 0) continue;
      win = int'(rnd[c]) % total;
      cumul = 0;
      for (int j = 0; j < rcount; j++) begin
        cumul += tkts[rlist[j]];
        if (cumul > win) begin
          run_slot[c] = rlist[j];
          for (int k = j; k < rcount - 1; k++) rlist[k] = rlist[k+1];
          rcount--;
          run_busy[c] = 1; qleft[c] = quantum_len; disp[c] = 1;
          break;
        end
      end
    end
    for (int c = 0; c < n_act; c++) begin
      if (run_busy[c]) begin
        if (work_left[run_slot[c]] > 0) work_left[run_slot[c]]--;
        if (qleft[c] > 0) qleft[c]--;
      end
      r.cpu = c[lcs_pkg::CPU_W-1:0];
      r.busy_res = run_busy[c];
      r.running_slot = run_busy[c] ? run_slot[c] : '0;
      r.dispatched = disp[c];
      r.finished = fin[c];
      r.finished_slot = fslot[c];
      r.last = (c + 1 == n_act);
      sched_q = {sched_q, r};
    end
  endtask

  always @(posedge clk) begin
    int nbusy;
    logic [lcs_pkg::RAND_W-1:0] rnd[lcs_pkg::CPUS];
    sched_res_t got, want;
    if (!rst_n) begin
      quantum_len <= lcs_pkg::QUANTUM_RESET;
      active_reg <= 3'd1;
      rcount = 0;
      for (int c = 0; c < lcs_pkg::CPUS; c++) begin
        run_busy[c] = 0; run_slot[c] = '0; qleft[c] = '0;
      end
      sched_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == lcs_pkg::REG_QUANTUM)
          quantum_len <= cfg_pwdata[lcs_pkg::QNT_W-1:0];
        else if (cfg_paddr == lcs_pkg::REG_ACTIVE)
          active_reg <= cfg_pwdata[lcs_pkg::ACT_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == lcs_pkg::FUNC_ADMIT) begin
          nbusy = 0;
          for (int c = 0; c < lcs_pkg::CPUS; c++) if (run_busy[c]) nbusy++;
          if (rcount + nbusy < lcs_pkg::SLOTS) begin
            tkts[in_ch.slot] = in_ch.tickets;
            work_left[in_ch.slot] = in_ch.burst;
            rlist[rcount] = in_ch.slot; rcount++;
          end
        end else begin
          rnd[0] = in_ch.rand_0; rnd[1] = in_ch.rand_1;
          rnd[2] = in_ch.rand_2; rnd[3] = in_ch.rand_3;
          schedule_tick(rnd);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cpu, out_ch.busy_res, out_ch.running_slot, out_ch.dispatched,
                out_ch.finished, out_ch.finished_slot, out_ch.last};
        if (sched_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = sched_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("result mismatch: exp %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    sched_pending = sched_q.size();
  end

endmodule

// File: sim/tb_lottery_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// tb_lottery_cpu_scheduler: stimulus and verdict for the lottery scheduler
// directed admits and ticks, then random process mixes under several quantum
// and cpu settings, one of them stall-free, else with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_lottery_cpu_scheduler;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, sched_pending;
  int          quiet_cycles = 0;
  bit          no_stall = 0;

  lcs_in_if  in_ch();
  lcs_out_if out_ch();

  lottery_cpu_scheduler dut (.clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_pready);

  lcs_checker chk (.clk, .rst_n, .in_ch, .out_ch, .cfg_psel, .cfg_penable, .cfg_pwrite,
    .cfg_pready, .cfg_paddr, .cfg_pwdata, .fail_count, .sched_pending);

  always #2 clk = ~clk;

  // result side backpressure
  always @(negedge clk)
    out_ch.ready <= no_stall || ($urandom_range(99) >= 33);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic send_item(input logic func, input logic [3:0] slot,
                           input logic [7:0] tkt, input logic [15:0] burst,
                           input logic [63:0] rnd);
    @(negedge clk);
    while (!no_stall && $urandom_range(99) < 33) @(negedge clk);
    in_ch.valid <= 1; in_ch.func <= func; in_ch.slot <= slot; in_ch.tickets <= tkt;
    in_ch.burst <= burst;
    {in_ch.rand_3, in_ch.rand_2, in_ch.rand_1, in_ch.rand_0} <= rnd;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  task automatic admit(input logic [3:0] slot, input logic [7:0] tkt,
                       input logic [15:0] burst);
    send_item(lcs_pkg::FUNC_ADMIT, slot, tkt, burst, {$urandom, $urandom});
  endtask

  task automatic tick(input logic [63:0] rnd);
    send_item(lcs_pkg::FUNC_TICK, 4'($urandom), 8'($urandom), 16'($urandom), rnd);
  endtask

  // let all results drain, then cover the block's own tail latency
  task automatic settle();
    while (sched_pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40)
        admit(4'($urandom), 8'($urandom_range(255, 1)), ($urandom_range(9) == 0) ?
              16'($urandom) : 16'($urandom_range(12, 1)));
      else
        tick({$urandom, $urandom});
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.func = 0; in_ch.slot = '0; in_ch.tickets = '0;
    in_ch.burst = '0; in_ch.rand_0 = '0; in_ch.rand_1 = '0; in_ch.rand_2 = '0;
    in_ch.rand_3 = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    // directed: field extremes, default quantum, one cpu
    admit(4'd0, 8'd1, 16'd1);
    admit(4'd15, 8'd255, 16'd65535);
    admit(4'd7, 8'd128, 16'd2);
    tick(64'hFFFF_FFFF_FFFF_FFFF);
    tick('0);
    tick(64'h0000_0000_0000_8000);
    admit(4'd7, 8'd64, 16'd32768);
    repeat (4) tick({$urandom, $urandom});
    settle();
    reg_write(lcs_pkg::REG_QUANTUM, 32'd1);
    reg_write(lcs_pkg::REG_ACTIVE, 32'd4);
    // fill the list until admits are refused
    for (int i = 0; i < 18; i++) admit(i[3:0], 8'($urandom_range(255, 1)), 16'd3);
    repeat (5) tick({$urandom, $urandom});
    settle();
    reg_write(lcs_pkg::REG_ACTIVE, 32'd0);
    reg_write(lcs_pkg::REG_QUANTUM, 32'd255);
    random_phase(20);
    settle();
    no_stall = 1;
    reg_write(lcs_pkg::REG_ACTIVE, 32'd7);
    reg_write(lcs_pkg::REG_QUANTUM, 32'd0);
    random_phase(18);
    settle();
    no_stall = 0;
    reg_write(lcs_pkg::REG_ACTIVE, 32'd2);
    reg_write(lcs_pkg::REG_QUANTUM, 32'd2);
    random_phase(20);
    settle();
    reg_write(lcs_pkg::REG_ACTIVE, 32'd3);
    reg_write(lcs_pkg::REG_QUANTUM, 32'($urandom_range(255, 1)));
    random_phase(18);
    settle();
    if (fail_count == 0 && sched_pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
